### rtl/lpf_pkg.sv
package lpf_pkg;

  // Default operand width of the block.
  localparam int LPF_WIDTH = 32;

  // Number of steps in the control program and the width of the step counter.
  localparam int LPF_STEPS  = 10;
  localparam int LPF_PC_W   = 4;

  typedef logic [LPF_PC_W-1:0] lpf_pc_t;

  // Datapath operations selected by one control word.
  typedef enum logic [2:0] {
    OP_NOP,
    OP_LOAD,
    OP_HALVE,
    OP_DIV_START,
    OP_TRIAL,
    OP_FINAL,
    OP_EMIT
  } lpf_op_t;

  // Jump conditions: when the condition holds, the step counter takes the
  // target, otherwise it moves on to the next step.
  typedef enum logic [2:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_INPUT,
    C_LE1_OR_ODD,
    C_LE1,
    C_DIV_BUSY,
    C_D_GT_Q,
    C_OUT_BLOCKED
  } lpf_cond_t;

  // One control word of the program.
  typedef struct packed {
    lpf_op_t   op;
    lpf_cond_t cond;
    lpf_pc_t   target;
  } lpf_uword_t;

  // Status flags from the datapath that the sequencer branches on.
  typedef struct packed {
    logic in_valid;
    logic n_le1;
    logic n_odd;
    logic div_busy;
    logic d_gt_q;
    logic out_blocked;
  } lpf_flags_t;

  // Step numbers that the program jumps to.
  localparam lpf_pc_t PC_IDLE  = 4'd0;
  localparam lpf_pc_t PC_EVEN  = 4'd1;
  localparam lpf_pc_t PC_ODD   = 4'd3;
  localparam lpf_pc_t PC_WAIT  = 4'd4;
  localparam lpf_pc_t PC_FINAL = 4'd7;
  localparam lpf_pc_t PC_EMIT  = 4'd8;

  // The control program held in read-only storage.
  function automatic lpf_uword_t lpf_rom(input lpf_pc_t pc);
    lpf_uword_t w;
    case (pc)
      4'd0:    w = '{op: OP_LOAD,      cond: C_NO_INPUT,    target: PC_IDLE};
      4'd1:    w = '{op: OP_NOP,       cond: C_LE1_OR_ODD,  target: PC_ODD};
      4'd2:    w = '{op: OP_HALVE,     cond: C_ALWAYS,      target: PC_EVEN};
      4'd3:    w = '{op: OP_DIV_START, cond: C_LE1,         target: PC_FINAL};
      4'd4:    w = '{op: OP_NOP,       cond: C_DIV_BUSY,    target: PC_WAIT};
      4'd5:    w = '{op: OP_NOP,       cond: C_D_GT_Q,      target: PC_FINAL};
      4'd6:    w = '{op: OP_TRIAL,     cond: C_ALWAYS,      target: PC_ODD};
      4'd7:    w = '{op: OP_FINAL,     cond: C_NEVER,       target: PC_IDLE};
      4'd8:    w = '{op: OP_EMIT,      cond: C_OUT_BLOCKED, target: PC_EMIT};
      4'd9:    w = '{op: OP_NOP,       cond: C_ALWAYS,      target: PC_IDLE};
      default: w = '{op: OP_NOP,       cond: C_ALWAYS,      target: PC_IDLE};
    endcase
    return w;
  endfunction

endpackage

### rtl/largest_prime_factor.sv
// Largest prime factor by trial division. Each word on the input gives one
// result word: the largest prime that divides the number, or 1 with found
// low when the number is 0 or 1. Factors of two are stripped first; odd
// divisors 3, 5, 7, ... are then tried up to the square root of what is
// left, and every trial costs one pass of a bit-serial divider plus four
// control steps. The trial loop through the shared divider sets the time
// an item takes, which is longest for a prime n. A finished result waits
// in an output register, so the next word can be taken while it is still
// pending.
module largest_prime_factor
  import lpf_pkg::*;
#(
  parameter int WIDTH = LPF_WIDTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [WIDTH-1:0] in_number,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [WIDTH-1:0] out_largest_prime,
  output logic             out_found
);

  lpf_op_t    op;
  lpf_flags_t flags;

  logic [WIDTH-1:0] n_r, n_nxt;
  logic [WIDTH-1:0] d_r, d_nxt;
  logic [WIDTH-1:0] best_r, best_nxt;
  logic             found_r, found_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [WIDTH-1:0] out_prime_r, out_prime_nxt;
  logic             out_found_r, out_found_nxt;

  logic             div_start;
  logic             div_busy;
  logic [WIDTH-1:0] div_q;
  logic [WIDTH-1:0] div_rem;
  logic             n_le1;
  logic             out_free;

  // Sequencer that runs the control program.
  lpf_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .flags (flags),
    .op    (op)
  );

  // Shared divider giving n / d and n % d for each trial.
  lpf_div #(
    .WIDTH (WIDTH)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (n_r),
    .divisor   (d_r),
    .busy      (div_busy),
    .quotient  (div_q),
    .remainder (div_rem)
  );

  assign n_le1     = (n_r[WIDTH-1:1] == '0);
  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (op == OP_LOAD);
  assign div_start = (op == OP_DIV_START) && !n_le1;

  // Status flags for the branch conditions.
  always_comb begin
    flags.in_valid    = in_valid;
    flags.n_le1       = n_le1;
    flags.n_odd       = n_r[0];
    flags.div_busy    = div_busy;
    flags.d_gt_q      = (d_r > div_q);
    flags.out_blocked = !out_free;
  end

  // Datapath actions selected by the current control word.
  always_comb begin
    n_nxt         = n_r;
    d_nxt         = d_r;
    best_nxt      = best_r;
    found_nxt     = found_r;
    out_valid_nxt = out_valid_r;
    out_prime_nxt = out_prime_r;
    out_found_nxt = out_found_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    case (op)
      OP_LOAD: begin
        if (in_valid) begin
          n_nxt     = in_number;
          d_nxt     = WIDTH'(3);
          best_nxt  = WIDTH'(1);
          found_nxt = (in_number[WIDTH-1:1] != '0);
        end
      end
      OP_HALVE: begin
        best_nxt = WIDTH'(2);
        n_nxt    = {1'b0, n_r[WIDTH-1:1]};
      end
      OP_TRIAL: begin
        if (div_rem == '0) begin
          best_nxt = d_r;
          n_nxt    = div_q;
        end else begin
          d_nxt = d_r + WIDTH'(2);
        end
      end
      OP_FINAL: begin
        if (!n_le1) begin
          best_nxt = n_r;
        end
      end
      OP_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_prime_nxt = best_r;
          out_found_nxt = found_r;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    n_r         <= n_nxt;
    d_r         <= d_nxt;
    best_r      <= best_nxt;
    found_r     <= found_nxt;
    out_prime_r <= out_prime_nxt;
    out_found_r <= out_found_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_largest_prime = out_prime_r;
  assign out_found         = out_found_r;

endmodule

### rtl/lpf_div.sv
module lpf_div
  import lpf_pkg::*;
#(
  parameter int WIDTH = LPF_WIDTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [WIDTH-1:0] dividend,
  input  logic [WIDTH-1:0] divisor,
  output logic             busy,
  output logic [WIDTH-1:0] quotient,
  output logic [WIDTH-1:0] remainder
);

  localparam int CW = $clog2(WIDTH + 1);

  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic [WIDTH-1:0] quo_r, quo_nxt;
  logic [WIDTH-1:0] rem_r, rem_nxt;
  logic [WIDTH-1:0] den_r, den_nxt;
  logic [WIDTH:0]   trial;
  logic [WIDTH:0]   diff;

  // One quotient bit per cycle: shift in the next dividend bit and subtract
  // the divisor when it fits.
  always_comb begin
    trial   = {rem_r, quo_r[WIDTH-1]};
    diff    = trial - {1'b0, den_r};
    cnt_nxt = cnt_r;
    quo_nxt = quo_r;
    rem_nxt = rem_r;
    den_nxt = den_r;
    if (start) begin
      cnt_nxt = CW'(WIDTH);
      quo_nxt = dividend;
      rem_nxt = '0;
      den_nxt = divisor;
    end else if (cnt_r != '0) begin
      cnt_nxt = cnt_r - 1'b1;
      if (!diff[WIDTH]) begin
        rem_nxt = diff[WIDTH-1:0];
        quo_nxt = {quo_r[WIDTH-2:0], 1'b1};
      end else begin
        rem_nxt = trial[WIDTH-1:0];
        quo_nxt = {quo_r[WIDTH-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  assign busy      = (cnt_r != '0);
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule

### rtl/lpf_seq.sv
module lpf_seq
  import lpf_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  lpf_flags_t flags,
  output lpf_op_t    op
);

  lpf_pc_t    pc_r, pc_nxt;
  lpf_uword_t uword;
  logic       take;

  assign uword = lpf_rom(pc_r);
  assign op    = uword.op;

  // Evaluate the jump condition of the current control word.
  always_comb begin
    case (uword.cond)
      C_NEVER:       take = 1'b0;
      C_ALWAYS:      take = 1'b1;
      C_NO_INPUT:    take = !flags.in_valid;
      C_LE1_OR_ODD:  take = flags.n_le1 || flags.n_odd;
      C_LE1:         take = flags.n_le1;
      C_DIV_BUSY:    take = flags.div_busy;
      C_D_GT_Q:      take = flags.d_gt_q;
      C_OUT_BLOCKED: take = flags.out_blocked;
      default:       take = 1'b1;
    endcase
    pc_nxt = take ? uword.target : pc_r + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= PC_IDLE;
    end else begin
      pc_r <= pc_nxt;
    end
  end

endmodule

### tb/largest_prime_factor_test.sv
module largest_prime_factor_test
  import lpf_pkg::*;
;

  localparam int WIDTH          = LPF_WIDTH;
  localparam int RANDOM_WORDS   = 70;
  localparam int HOLD_OFF       = 600;
  localparam int BURST_WORDS    = 6;
  localparam int DRAIN_CYCLES   = 200;
  // The slowest word here is the prime just below 2**20.
  localparam int WATCHDOG_LIMIT = 200000;
  localparam int DIRECTED_ROWS  = 23;

  // One result word as the block reports it.
  typedef struct packed {
    logic [WIDTH-1:0] prime;
    logic             found;
  } factor_word_t;

  // One row of the directed table. Where typed is clear, the predictor
  // supplies the expected result.
  typedef struct packed {
    logic [WIDTH-1:0] number;
    logic             typed;
    logic [WIDTH-1:0] prime;
    logic             found;
  } directed_row_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_ready;
  logic [WIDTH-1:0] in_number = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic [WIDTH-1:0] out_largest_prime;
  logic             out_found;

  factor_word_t pending_factors[$];
  int           mismatches = 0;
  int           quiet_cycles = 0;
  int           tx_idle_pct = 0;
  int           rx_idle_pct = 0;
  int           hold_cycles = 0;
  logic         hold_req = 1'b0;
  logic         hold_taken = 1'b0;

  // Extremes, numbers without a factor and a few primes are typed in; the
  // rest is left to the predictor.
  directed_row_t directed_rows [DIRECTED_ROWS] = '{
    '{32'd0,           1'b1, 32'd1,     1'b0},
    '{32'd1,           1'b1, 32'd1,     1'b0},
    '{32'd2,           1'b1, 32'd2,     1'b1},
    '{32'd3,           1'b1, 32'd3,     1'b1},
    '{32'd4,           1'b1, 32'd2,     1'b1},
    '{32'h8000_0000,   1'b1, 32'd2,     1'b1},
    '{32'hFFFF_FFFF,   1'b1, 32'd65537, 1'b1},
    '{32'd65537,       1'b1, 32'd65537, 1'b1},
    '{32'd6,           1'b0, 32'd0,     1'b0},
    '{32'd9,           1'b0, 32'd0,     1'b0},
    '{32'd25,          1'b0, 32'd0,     1'b0},
    '{32'd49,          1'b0, 32'd0,     1'b0},
    '{32'd97,          1'b0, 32'd0,     1'b0},
    '{32'd13195,       1'b0, 32'd0,     1'b0},
    '{32'h0000_FFFF,   1'b0, 32'd0,     1'b0},
    '{32'h5555_5555,   1'b0, 32'd0,     1'b0},
    '{32'hAAAA_AAAA,   1'b0, 32'd0,     1'b0},
    '{32'hFFFF_FFF0,   1'b0, 32'd0,     1'b0},
    '{32'd1048573,     1'b0, 32'd0,     1'b0},
    '{32'h7FFF_0000,   1'b0, 32'd0,     1'b0},
    '{32'hC000_0000,   1'b0, 32'd0,     1'b0},
    '{32'h0F0F_0F0F,   1'b0, 32'd0,     1'b0},
    '{32'hF0F0_F0F0,   1'b0, 32'd0,     1'b0}
  };

  // Clock with a period of ten time units.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  largest_prime_factor #(
    .WIDTH(WIDTH)
  ) i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_number        (in_number),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_largest_prime(out_largest_prime),
    .out_found        (out_found)
  );

  // Trial division: strip the twos, then odd divisors up to the square root
  // of what is left; anything above one at the end is the largest factor.
  function automatic factor_word_t largest_prime_of(input logic [WIDTH-1:0] number);
    factor_word_t      result;
    longint unsigned   rest;
    longint unsigned   divisor;
    longint unsigned   best;
    rest = number;
    best = 1;
    if (rest < 2) begin
      result.prime = WIDTH'(1);
      result.found = 1'b0;
      return result;
    end
    while (rest > 1 && (rest & 1) == 0) begin
      best = 2;
      rest = rest >> 1;
    end
    divisor = 3;
    while (rest > 1 && divisor <= rest / divisor) begin
      if (rest % divisor == 0) begin
        best = divisor;
        rest = rest / divisor;
      end else begin
        divisor = divisor + 2;
      end
    end
    if (rest > 1)
      best = rest;
    result.prime = best[WIDTH-1:0];
    result.found = 1'b1;
    return result;
  endfunction

  // A product of small factors not above a ceiling. Every prime in it is
  // below 256.
  function automatic logic [WIDTH-1:0] smooth_number(input longint unsigned ceiling);
    longint unsigned product;
    longint unsigned factor;
    int              count;
    product = 1;
    count = $urandom_range(1, 14);
    repeat (count) begin
      factor = $urandom_range(2, 255);
      if (product * factor <= ceiling)
        product = product * factor;
    end
    return product[WIDTH-1:0];
  endfunction

  // Mostly full-width smooth numbers, some with a random 16-bit cofactor,
  // then narrow random noise and the odd edge value.
  function automatic logic [WIDTH-1:0] random_number();
    int               pick;
    logic [WIDTH-1:0] value;
    pick = $urandom_range(99);
    if (pick < 60)
      value = smooth_number(64'hFFFF_FFFF);
    else if (pick < 85)
      value = smooth_number(64'hFFFF) * WIDTH'($urandom_range(1, 16'hFFFF));
    else if (pick < 95)
      value = $urandom() & ((32'd1 << $urandom_range(1, 18)) - 32'd1);
    else if (pick < 97)
      value = WIDTH'($urandom_range(0, 1));
    else
      value = 32'd1 << $urandom_range(0, 31);
    return value;
  endfunction

  task automatic report_mismatch(input string what, input logic [WIDTH-1:0] got,
                                 input logic [WIDTH-1:0] want);
    $display("MISMATCH at %0t: %s is %0d, expected %0d", $time, what, got, want);
    mismatches++;
  endtask

  // Offer one word, wait for it to be taken and then idle at random.
  task automatic send_number(input logic [WIDTH-1:0] number, input factor_word_t want);
    in_valid  <= 1'b1;
    in_number <= number;
    @(posedge clk);
    while (!in_ready)
      @(posedge clk);
    pending_factors = {pending_factors, want};
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  // The receiver either sits out a long hold-off or stalls at random.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_req && !hold_taken) begin
      out_ready   <= 1'b0;
      hold_taken  <= 1'b1;
      hold_cycles <= HOLD_OFF;
    end else if (hold_cycles > 0) begin
      out_ready   <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Each result word is compared with the oldest expectation.
  always @(posedge clk) begin : check_results
    factor_word_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_factors.size() == 0) begin
        report_mismatch("unexpected word, largest_prime", out_largest_prime, '0);
      end else begin
        want = pending_factors.pop_front();
        if (out_largest_prime !== want.prime)
          report_mismatch("largest_prime", out_largest_prime, want.prime);
        if (out_found !== want.found)
          report_mismatch("found", WIDTH'(out_found), WIDTH'(want.found));
      end
    end
  end

  // The run is abandoned after a long stretch with no word moving.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Stimulus: directed table, then random words in three idling phases with
  // a back-pressure burst before the last one.
  initial begin
    logic [WIDTH-1:0] number;
    factor_word_t     typed_result;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    tx_idle_pct = 10;
    rx_idle_pct = 55;
    foreach (directed_rows[i]) begin
      typed_result.prime = directed_rows[i].prime;
      typed_result.found = directed_rows[i].found;
      send_number(directed_rows[i].number,
                  directed_rows[i].typed ? typed_result
                                         : largest_prime_of(directed_rows[i].number));
    end
    repeat (RANDOM_WORDS / 3) begin
      number = random_number();
      send_number(number, largest_prime_of(number));
    end

    tx_idle_pct = 55;
    rx_idle_pct = 10;
    repeat (RANDOM_WORDS / 3) begin
      number = random_number();
      send_number(number, largest_prime_of(number));
    end

    // Cheap words while the receiver holds off, so the block fills up and
    // has to stall its input.
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    hold_req = 1'b1;
    repeat (BURST_WORDS) begin
      number = 32'd3 << $urandom_range(0, 30);
      send_number(number, largest_prime_of(number));
    end

    repeat (RANDOM_WORDS - 2 * (RANDOM_WORDS / 3)) begin
      number = random_number();
      send_number(number, largest_prime_of(number));
    end
    in_valid <= 1'b0;

    while (pending_factors.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
